// File: rtl/core/aqp_pkg.sv
// ----------------------------------------------------------------------------
// Attitude quaternion propagator package
// Shared types, codes, constants and helper functions of the propagator.
// ----------------------------------------------------------------------------
package aqp_pkg;

  localparam logic [31:0] InertiaReset  = 32'd65536;
  localparam logic [27:0] TimeStepReset = 28'd1677722;
  localparam logic [31:0] OneQ30        = 32'h4000_0000;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_INERTIA_X = 2'd0,
    CFG_INERTIA_Y = 2'd1,
    CFG_INERTIA_Z = 2'd2,
    CFG_TIME_STEP = 2'd3
  } cfg_reg_t;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_RMUL,
    OP_RDIV,
    OP_RUPD,
    OP_HMUL,
    OP_HUPD,
    OP_QINIT,
    OP_QMUL,
    OP_QACC,
    OP_QRND,
    OP_QSQ,
    OP_QSUM,
    OP_SQRT,
    OP_NDIV,
    OP_NUPD,
    OP_IDENT,
    OP_OUT
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RMUL,
    ST_RDIV,
    ST_RDIVW,
    ST_RUPD,
    ST_HMUL,
    ST_HUPD,
    ST_QINIT,
    ST_QMUL,
    ST_QACC,
    ST_QRND,
    ST_QSQ,
    ST_QSUM,
    ST_SQRT,
    ST_SQRTW,
    ST_NDIV,
    ST_NDIVW,
    ST_NUPD,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] idx;
    logic [1:0] term;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic inert_zero;
    logic root_zero;
  } dp_status_t;

  // Attitude component that multiplies half-angle term 'term' in product component 'comp'.
  function automatic logic [1:0] quat_src(input logic [1:0] comp, input logic [1:0] term);
    case ({comp, term})
      4'b00_00: quat_src = 2'd1;
      4'b00_01: quat_src = 2'd2;
      4'b00_10: quat_src = 2'd3;
      4'b01_00: quat_src = 2'd0;
      4'b01_01: quat_src = 2'd3;
      4'b01_10: quat_src = 2'd2;
      4'b10_00: quat_src = 2'd3;
      4'b10_01: quat_src = 2'd0;
      4'b10_10: quat_src = 2'd1;
      4'b11_00: quat_src = 2'd2;
      4'b11_01: quat_src = 2'd1;
      4'b11_10: quat_src = 2'd0;
      default:  quat_src = 2'd0;
    endcase
  endfunction

  // True where that term is subtracted.
  function automatic logic quat_neg(input logic [1:0] comp, input logic [1:0] term);
    case ({comp, term})
      4'b00_00, 4'b00_01, 4'b00_10: quat_neg = 1'b1;
      4'b01_10, 4'b10_00, 4'b11_01: quat_neg = 1'b1;
      default:                      quat_neg = 1'b0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat_s32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      sat_s32 = 32'sh7fff_ffff;
    end else if (v < -66'sd2147483648) begin
      sat_s32 = 32'sh8000_0000;
    end else begin
      sat_s32 = v[31:0];
    end
  endfunction

endpackage

// File: rtl/core/aqp_if.sv
// ----------------------------------------------------------------------------
// Attitude quaternion propagator channels
// Valid/ready channels for torque items and attitude/rate results.
// ----------------------------------------------------------------------------
interface aqp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] torque_x;
  logic signed [31:0] torque_y;
  logic signed [31:0] torque_z;

  modport source (output valid, torque_x, torque_y, torque_z, input ready);
  modport sink (input valid, torque_x, torque_y, torque_z, output ready);
endinterface

interface aqp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] quat_w;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;
  logic signed [31:0] rate_x;
  logic signed [31:0] rate_y;
  logic signed [31:0] rate_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, rate_x, rate_y, rate_z,
                  input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, rate_x, rate_y, rate_z,
                output ready);
endinterface

// File: rtl/core/aqp_div.sv
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// 64-bit by 32-bit restoring division, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module aqp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic [63:0] quotient,
  output logic        done
);

  localparam int unsigned BitsPerCycle = 2;
  localparam int unsigned Cycles       = 64 / BitsPerCycle;
  localparam int unsigned CntW         = $clog2(Cycles);

  logic [63:0]     quo_r, quo_nxt;
  logic [31:0]     rem_r, rem_nxt;
  logic [31:0]     den_r;
  logic [CntW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;

  always_comb begin
    logic [32:0] tmp;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    tmp     = '0;
    for (int i = 0; i < BitsPerCycle; i++) begin
      tmp     = {rem_nxt, quo_nxt[63]};
      quo_nxt = {quo_nxt[62:0], 1'b0};
      if (tmp >= {1'b0, den_r}) begin
        tmp        = tmp - {1'b0, den_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = tmp[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CntW'(Cycles - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// File: rtl/core/aqp_sqrt.sv
// ----------------------------------------------------------------------------
// Iterative integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module aqp_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic [31:0] root,
  output logic        done
);

  logic [63:0] v_r, v_nxt;
  logic [63:0] r_r, r_nxt;
  logic [63:0] b_r;
  logic        busy_r;
  logic        done_r;

  always_comb begin
    logic [63:0] rb;
    rb = r_r + b_r;
    if (v_r >= rb) begin
      v_nxt = v_r - rb;
      r_nxt = (r_r >> 1) + b_r;
    end else begin
      v_nxt = v_r;
      r_nxt = r_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      // The lowest trial bit finishes the root.
      if (b_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r <= radicand;
      r_r <= '0;
      b_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      v_r <= v_nxt;
      r_r <= r_nxt;
      b_r <= b_r >> 2;
    end
  end

  assign root = r_r[31:0];
  assign done = done_r;

endmodule

// File: rtl/core/aqp_dp.sv
// ----------------------------------------------------------------------------
// Attitude quaternion propagator datapath
// State, configuration, shared multiplier, divider and square root unit.
// ----------------------------------------------------------------------------
module aqp_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  aqp_pkg::dp_cmd_t    cmd,
  output aqp_pkg::dp_status_t status,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata,
  input  logic signed [31:0]  torque_x,
  input  logic signed [31:0]  torque_y,
  input  logic signed [31:0]  torque_z,
  output logic signed [31:0]  quat_w,
  output logic signed [31:0]  quat_x,
  output logic signed [31:0]  quat_y,
  output logic signed [31:0]  quat_z,
  output logic signed [31:0]  rate_x,
  output logic signed [31:0]  rate_y,
  output logic signed [31:0]  rate_z
);

  logic [31:0]        inertia_r [3];
  logic [27:0]        time_step_r;
  logic signed [31:0] rate_r [3];
  logic signed [31:0] att_r [4];
  logic signed [31:0] trq_r [3];
  logic signed [31:0] h_r [3];
  logic signed [64:0] mul_r;
  logic signed [63:0] acc_r;
  logic [31:0]        mag_r [4];
  logic [3:0]         tneg_r;
  logic [63:0]        sumsq_r;
  logic signed [31:0] out_quat_r [4];
  logic signed [31:0] out_rate_r [3];

  logic [1:0]         att_sel;
  logic signed [31:0] att_rd;
  logic [31:0]        inertia_cur;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [64:0]        mul_mag;
  logic [63:0]        acc_mag;
  logic [32:0]        mround;
  logic signed [65:0] delta, rate_sum, h_val;
  logic [44:0]        h_rnd;
  logic signed [31:0] rate_sat, h_sat, att_new;
  logic [31:0]        norm_v;

  logic        div_start, div_done, sqrt_done;
  logic [63:0] div_dividend, div_quo;
  logic [31:0] div_divisor, root;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inertia_r[0] <= aqp_pkg::InertiaReset;
      inertia_r[1] <= aqp_pkg::InertiaReset;
      inertia_r[2] <= aqp_pkg::InertiaReset;
      time_step_r  <= aqp_pkg::TimeStepReset;
    end else if (cfg_wr_en) begin
      unique case (aqp_pkg::cfg_reg_t'(cfg_index))
        aqp_pkg::CFG_INERTIA_X: inertia_r[0] <= cfg_wdata;
        aqp_pkg::CFG_INERTIA_Y: inertia_r[1] <= cfg_wdata;
        aqp_pkg::CFG_INERTIA_Z: inertia_r[2] <= cfg_wdata;
        aqp_pkg::CFG_TIME_STEP: time_step_r  <= cfg_wdata[27:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    att_sel = (cmd.op == aqp_pkg::OP_QMUL) ? aqp_pkg::quat_src(cmd.idx, cmd.term) : cmd.idx;
    att_rd  = att_r[att_sel];
    case (cmd.idx)
      2'd1:    inertia_cur = inertia_r[1];
      2'd2:    inertia_cur = inertia_r[2];
      default: inertia_cur = inertia_r[0];
    endcase
  end

  // Shared multiplier operand selection.
  always_comb begin
    case (cmd.op)
      aqp_pkg::OP_RMUL: begin
        mul_a = {trq_r[cmd.idx][31], trq_r[cmd.idx]};
        mul_b = {5'd0, time_step_r};
      end
      aqp_pkg::OP_HMUL: begin
        mul_a = {rate_r[cmd.idx][31], rate_r[cmd.idx]};
        mul_b = {5'd0, time_step_r};
      end
      aqp_pkg::OP_QMUL: begin
        mul_a = {h_r[cmd.term][31], h_r[cmd.term]};
        mul_b = {att_rd[31], att_rd};
      end
      aqp_pkg::OP_QSQ: begin
        mul_a = {1'b0, mag_r[cmd.idx]};
        mul_b = {1'b0, mag_r[cmd.idx]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    mul_mag = mul_r[64] ? 65'(-mul_r) : 65'(mul_r);
    acc_mag = acc_r[63] ? 64'(-acc_r) : 64'(acc_r);
    mround  = 33'((65'(acc_mag) + 65'd1073741824) >> 31);

    // Rate update: zero inertia drives the rate toward the sign of the numerator.
    if (inertia_cur == 32'd0) begin
      if (mul_r > 65'sd0) begin
        delta = 66'sh100_0000_0000;
      end else if (mul_r < 65'sd0) begin
        delta = -66'sh100_0000_0000;
      end else begin
        delta = '0;
      end
    end else begin
      delta = mul_r[64] ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
    end
    rate_sum = delta + {{34{rate_r[cmd.idx][31]}}, rate_r[cmd.idx]};
    rate_sat = aqp_pkg::sat_s32(rate_sum);

    // Half angle: the factor one half sits in the shift.
    h_rnd = 45'((mul_mag[63:0] + 64'd262144) >> 19);
    h_val = mul_r[64] ? -$signed({21'd0, h_rnd}) : $signed({21'd0, h_rnd});
    h_sat = aqp_pkg::sat_s32(h_val);

    norm_v  = (div_quo > 64'(aqp_pkg::OneQ30)) ? aqp_pkg::OneQ30 : div_quo[31:0];
    att_new = tneg_r[cmd.idx] ? -$signed(norm_v) : $signed(norm_v);
  end

  always_comb begin
    div_start = ((cmd.op == aqp_pkg::OP_RDIV) && (inertia_cur != 32'd0)) ||
                (cmd.op == aqp_pkg::OP_NDIV);
    if (cmd.op == aqp_pkg::OP_NDIV) begin
      div_dividend = {2'b00, mag_r[cmd.idx], 30'd0} + {33'd0, root[31:1]};
      div_divisor  = root;
    end else begin
      div_dividend = mul_mag[63:0] + {33'd0, inertia_cur[31:1]};
      div_divisor  = inertia_cur;
    end
  end

  aqp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .done     (div_done)
  );

  aqp_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == aqp_pkg::OP_SQRT),
    .radicand (sumsq_r),
    .root     (root),
    .done     (sqrt_done)
  );

  // Propagated state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r[0] <= '0;
      rate_r[1] <= '0;
      rate_r[2] <= '0;
      att_r[0]  <= aqp_pkg::OneQ30;
      att_r[1]  <= '0;
      att_r[2]  <= '0;
      att_r[3]  <= '0;
    end else begin
      case (cmd.op)
        aqp_pkg::OP_RUPD: rate_r[cmd.idx] <= rate_sat;
        aqp_pkg::OP_NUPD: att_r[cmd.idx] <= att_new;
        aqp_pkg::OP_IDENT: begin
          att_r[0] <= aqp_pkg::OneQ30;
          att_r[1] <= '0;
          att_r[2] <= '0;
          att_r[3] <= '0;
        end
        default: ;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (cmd.op) inside
      aqp_pkg::OP_LOAD: begin
        trq_r[0] <= torque_x;
        trq_r[1] <= torque_y;
        trq_r[2] <= torque_z;
        sumsq_r  <= '0;
      end
      aqp_pkg::OP_RMUL, aqp_pkg::OP_HMUL, aqp_pkg::OP_QMUL, aqp_pkg::OP_QSQ:
        mul_r <= mul_p[64:0];
      aqp_pkg::OP_HUPD:  h_r[cmd.idx] <= h_sat;
      aqp_pkg::OP_QINIT: acc_r <= {{2{att_rd[31]}}, att_rd, 30'd0};
      aqp_pkg::OP_QACC: begin
        if (aqp_pkg::quat_neg(cmd.idx, cmd.term)) begin
          acc_r <= acc_r - mul_r[63:0];
        end else begin
          acc_r <= acc_r + mul_r[63:0];
        end
      end
      aqp_pkg::OP_QRND: begin
        mag_r[cmd.idx]  <= mround[31:0];
        tneg_r[cmd.idx] <= acc_r[63];
      end
      aqp_pkg::OP_QSUM: sumsq_r <= sumsq_r + mul_r[63:0];
      aqp_pkg::OP_OUT: begin
        out_quat_r <= att_r;
        out_rate_r <= rate_r;
      end
      default: ;
    endcase
  end

  assign status.div_done   = div_done;
  assign status.sqrt_done  = sqrt_done;
  assign status.inert_zero = (inertia_cur == 32'd0);
  assign status.root_zero  = (root == 32'd0);

  assign quat_w = out_quat_r[0];
  assign quat_x = out_quat_r[1];
  assign quat_y = out_quat_r[2];
  assign quat_z = out_quat_r[3];
  assign rate_x = out_rate_r[0];
  assign rate_y = out_rate_r[1];
  assign rate_z = out_rate_r[2];

endmodule

// File: rtl/core/aqp_ctrl.sv
// ----------------------------------------------------------------------------
// Attitude quaternion propagator controller
// Sequences the datapath through rate, product and normalization steps.
// ----------------------------------------------------------------------------
module aqp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output aqp_pkg::dp_cmd_t    cmd,
  input  aqp_pkg::dp_status_t status
);

  aqp_pkg::ctrl_state_t state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [1:0] term_r, term_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aqp_pkg::ST_IDLE;
      idx_r       <= '0;
      term_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      term_r      <= term_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    term_nxt      = term_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    in_ready      = 1'b0;
    cmd.op        = aqp_pkg::OP_NOP;
    cmd.idx       = idx_r;
    cmd.term      = term_r;
    unique case (state_r)
      aqp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = aqp_pkg::OP_LOAD;
          idx_nxt   = '0;
          state_nxt = aqp_pkg::ST_RMUL;
        end
      end
      aqp_pkg::ST_RMUL: begin
        cmd.op    = aqp_pkg::OP_RMUL;
        state_nxt = aqp_pkg::ST_RDIV;
      end
      aqp_pkg::ST_RDIV: begin
        cmd.op    = aqp_pkg::OP_RDIV;
        state_nxt = status.inert_zero ? aqp_pkg::ST_RUPD : aqp_pkg::ST_RDIVW;
      end
      aqp_pkg::ST_RDIVW: begin
        if (status.div_done) begin
          state_nxt = aqp_pkg::ST_RUPD;
        end
      end
      aqp_pkg::ST_RUPD: begin
        cmd.op    = aqp_pkg::OP_RUPD;
        state_nxt = aqp_pkg::ST_HMUL;
      end
      aqp_pkg::ST_HMUL: begin
        cmd.op    = aqp_pkg::OP_HMUL;
        state_nxt = aqp_pkg::ST_HUPD;
      end
      aqp_pkg::ST_HUPD: begin
        cmd.op = aqp_pkg::OP_HUPD;
        if (idx_r == 2'd2) begin
          idx_nxt   = '0;
          state_nxt = aqp_pkg::ST_QINIT;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = aqp_pkg::ST_RMUL;
        end
      end
      aqp_pkg::ST_QINIT: begin
        cmd.op    = aqp_pkg::OP_QINIT;
        term_nxt  = '0;
        state_nxt = aqp_pkg::ST_QMUL;
      end
      aqp_pkg::ST_QMUL: begin
        cmd.op    = aqp_pkg::OP_QMUL;
        state_nxt = aqp_pkg::ST_QACC;
      end
      aqp_pkg::ST_QACC: begin
        cmd.op = aqp_pkg::OP_QACC;
        if (term_r == 2'd2) begin
          state_nxt = aqp_pkg::ST_QRND;
        end else begin
          term_nxt  = term_r + 2'd1;
          state_nxt = aqp_pkg::ST_QMUL;
        end
      end
      aqp_pkg::ST_QRND: begin
        cmd.op    = aqp_pkg::OP_QRND;
        state_nxt = aqp_pkg::ST_QSQ;
      end
      aqp_pkg::ST_QSQ: begin
        cmd.op    = aqp_pkg::OP_QSQ;
        state_nxt = aqp_pkg::ST_QSUM;
      end
      aqp_pkg::ST_QSUM: begin
        cmd.op = aqp_pkg::OP_QSUM;
        if (idx_r == 2'd3) begin
          idx_nxt   = '0;
          state_nxt = aqp_pkg::ST_SQRT;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = aqp_pkg::ST_QINIT;
        end
      end
      aqp_pkg::ST_SQRT: begin
        cmd.op    = aqp_pkg::OP_SQRT;
        state_nxt = aqp_pkg::ST_SQRTW;
      end
      aqp_pkg::ST_SQRTW: begin
        if (status.sqrt_done) begin
          // A zero norm leaves nothing to scale, so the attitude restarts at identity.
          if (status.root_zero) begin
            cmd.op    = aqp_pkg::OP_IDENT;
            state_nxt = aqp_pkg::ST_OUT;
          end else begin
            state_nxt = aqp_pkg::ST_NDIV;
          end
        end
      end
      aqp_pkg::ST_NDIV: begin
        cmd.op    = aqp_pkg::OP_NDIV;
        state_nxt = aqp_pkg::ST_NDIVW;
      end
      aqp_pkg::ST_NDIVW: begin
        if (status.div_done) begin
          state_nxt = aqp_pkg::ST_NUPD;
        end
      end
      aqp_pkg::ST_NUPD: begin
        cmd.op = aqp_pkg::OP_NUPD;
        if (idx_r == 2'd3) begin
          state_nxt = aqp_pkg::ST_OUT;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = aqp_pkg::ST_NDIV;
        end
      end
      aqp_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = aqp_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = aqp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = aqp_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/attitude_quaternion_propagator.sv
// The time from an input transfer to its result is set mostly by the shared divider
// (seven divides, two quotient bits per cycle) and the square root; a zero inertia skips
// that axis's divide.
// The next item is taken once a result reaches the output register, also while that
// result still waits there.
// Reset (synchronous, rst_n low): rate zero, attitude identity, configuration to defaults.
// ----------------------------------------------------------------------------
// Attitude quaternion propagator
// Euler step of body rate and attitude quaternion with renormalization.
// ----------------------------------------------------------------------------
module attitude_quaternion_propagator (
  input  logic        clk,
  input  logic        rst_n,
  aqp_in_if.sink      in_ch,
  aqp_out_if.source   out_ch,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  aqp_pkg::dp_cmd_t    cmd;
  aqp_pkg::dp_status_t status;

  aqp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  aqp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .torque_x  (in_ch.torque_x),
    .torque_y  (in_ch.torque_y),
    .torque_z  (in_ch.torque_z),
    .quat_w    (out_ch.quat_w),
    .quat_x    (out_ch.quat_x),
    .quat_y    (out_ch.quat_y),
    .quat_z    (out_ch.quat_z),
    .rate_x    (out_ch.rate_x),
    .rate_y    (out_ch.rate_y),
    .rate_z    (out_ch.rate_z)
  );

endmodule

// File: test/attitude_quaternion_propagator_tb.sv
// ----------------------------------------------------------------------------
// Attitude quaternion propagator testbench
// Drives torque vectors through the input channel under several inertia and
// time-step settings. Each result is compared field by field with its row's
// typed value or a bench model of the Euler step: the rate update with
// saturation, the half-angle product, the renormalisation and its special cases.
// ----------------------------------------------------------------------------
module attitude_quaternion_propagator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  SettingCount = 8;
  localparam int  ItemsPerSetting = 69;
  localparam int  StallLimit = 5000;
  localparam int  SettleCycles = 400;
  localparam longint OneQ30L = 64'sd1073741824;
  localparam longint RateKick = 64'sd1099511627776;

  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
  } attitude_t;

  typedef struct {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    bit                 typed;
    attitude_t          want;
  } torque_row_t;

  typedef struct {
    bit        typed;
    attitude_t want;
  } typed_note_t;

  logic clk;
  logic rst_n;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  aqp_in_if  in_ch ();
  aqp_out_if out_ch ();

  attitude_quaternion_propagator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Bench copy of the block's registers and state.
  logic [31:0]        inertia_q16 [3];
  logic [27:0]        step_q24;
  logic signed [31:0] body_rate [3];
  logic signed [31:0] attitude_q30 [4];

  attitude_t   attitude_queue [$];
  typed_note_t typed_notes [$];
  int          fail_count;
  int          torques_taken;
  int          results_seen;
  int          idle_cycles;
  int          send_idle_pct;
  int          recv_idle_pct;

  torque_row_t directed_rows [12] = '{
    '{32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b1,
      '{32'sh4000_0000, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}},
    '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0, '0},
    '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0, '0},
    '{32'sh0000_0001, 32'shffff_ffff, 32'sh0000_0000, 1'b0, '0},
    '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0001, 1'b0, '0},
    '{32'shffff_ffff, 32'shffff_ffff, 32'shffff_ffff, 1'b0, '0},
    '{32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b0, '0},
    '{32'sh8000_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b0, '0},
    '{32'shffff_0000, 32'sh0001_0000, 32'sh0000_8000, 1'b0, '0},
    '{32'sh0000_0064, 32'shffff_ff38, 32'sh0000_012c, 1'b0, '0},
    '{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0f0f_0f0f, 1'b0, '0},
    '{32'shaaaa_aaaa, 32'sh5555_5555, 32'shf0f0_f0f0, 1'b0, '0}
  };

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Division rounded half away from zero.
  function automatic longint round_div(input longint num, input longint unsigned den);
    bit                neg;
    longint unsigned   mag;
    longint unsigned   quo;
    neg = num < 0;
    mag = neg ? longint'(-num) : longint'(num);
    quo = (mag + den / 2) / den;
    return neg ? -longint'(quo) : longint'(quo);
  endfunction

  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // One Euler step: updates the bench state and returns the expected result.
  function automatic attitude_t euler_step(input logic signed [31:0] tx,
                                           input logic signed [31:0] ty,
                                           input logic signed [31:0] tz);
    logic signed [31:0] torque [3];
    longint             dts;
    longint             num;
    longint             delta;
    longint             h [3];
    longint             q [4];
    longint             s [4];
    longint             t [4];
    longint unsigned    sumsq;
    longint unsigned    root;
    longint unsigned    m;
    longint unsigned    v;
    attitude_t          res;
    torque[0] = tx;
    torque[1] = ty;
    torque[2] = tz;
    dts = longint'({36'd0, step_q24});
    for (int i = 0; i < 3; i++) begin
      num = longint'(torque[i]) * dts;
      if (inertia_q16[i] == 0) begin
        delta = num > 0 ? RateKick : (num < 0 ? -RateKick : 64'sd0);
      end else begin
        delta = round_div(num, {32'd0, inertia_q16[i]});
      end
      body_rate[i] = 32'(clip32(longint'(body_rate[i]) + delta));
      h[i] = clip32(round_div(longint'(body_rate[i]) * dts, 64'd524288));
    end
    for (int i = 0; i < 4; i++) q[i] = longint'(attitude_q30[i]);
    s[0] = q[0] * OneQ30L - h[0] * q[1] - h[1] * q[2] - h[2] * q[3];
    s[1] = q[1] * OneQ30L + h[0] * q[0] + h[1] * q[3] - h[2] * q[2];
    s[2] = q[2] * OneQ30L - h[0] * q[3] + h[1] * q[0] + h[2] * q[1];
    s[3] = q[3] * OneQ30L + h[0] * q[2] - h[1] * q[1] + h[2] * q[0];
    sumsq = 0;
    for (int i = 0; i < 4; i++) begin
      t[i] = round_div(s[i], 64'd2147483648);
      m = t[i] < 0 ? longint'(-t[i]) : longint'(t[i]);
      sumsq = sumsq + m * m;
    end
    root = root64(sumsq);
    if (root == 0) begin
      // A vanishing norm falls back to the identity attitude.
      attitude_q30[0] = aqp_pkg::OneQ30;
      for (int i = 1; i < 4; i++) attitude_q30[i] = '0;
    end else begin
      for (int i = 0; i < 4; i++) begin
        m = t[i] < 0 ? longint'(-t[i]) : longint'(t[i]);
        v = (m * 64'd1073741824 + root / 2) / root;
        if (v > 64'd1073741824) v = 64'd1073741824;
        attitude_q30[i] = t[i] < 0 ? 32'(-longint'(v)) : 32'(longint'(v));
      end
    end
    res.quat_w = attitude_q30[0];
    res.quat_x = attitude_q30[1];
    res.quat_y = attitude_q30[2];
    res.quat_z = attitude_q30[3];
    res.rate_x = body_rate[0];
    res.rate_y = body_rate[1];
    res.rate_z = body_rate[2];
    return res;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: ready is redrawn every cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  // Transfer monitor, scoreboard and watchdog.
  always @(posedge clk) begin
    attitude_t   want;
    attitude_t   got;
    attitude_t   pred;
    typed_note_t note;
    if (rst_n) begin
      idle_cycles++;
      if (out_ch.valid && out_ch.ready) begin
        idle_cycles = 0;
        results_seen++;
        got = '{out_ch.quat_w, out_ch.quat_x, out_ch.quat_y, out_ch.quat_z,
                out_ch.rate_x, out_ch.rate_y, out_ch.rate_z};
        if (attitude_queue.size() == 0) begin
          $error("result transfer with no torque item outstanding");
          fail_count++;
        end else begin
          want = attitude_queue.pop_front();
          check_field("quat_w", want.quat_w, got.quat_w);
          check_field("quat_x", want.quat_x, got.quat_x);
          check_field("quat_y", want.quat_y, got.quat_y);
          check_field("quat_z", want.quat_z, got.quat_z);
          check_field("rate_x", want.rate_x, got.rate_x);
          check_field("rate_y", want.rate_y, got.rate_y);
          check_field("rate_z", want.rate_z, got.rate_z);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        idle_cycles = 0;
        torques_taken++;
        pred = euler_step(in_ch.torque_x, in_ch.torque_y, in_ch.torque_z);
        note = typed_notes.pop_front();
        attitude_queue.push_back(note.typed ? note.want : pred);
      end
      if (idle_cycles >= StallLimit) begin
        $display("attitude_quaternion_propagator_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic send_torque(input logic signed [31:0] tx, input logic signed [31:0] ty,
                             input logic signed [31:0] tz, input bit typed,
                             input attitude_t want);
    typed_notes.push_back('{typed, want});
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.torque_x <= tx;
    in_ch.torque_y <= ty;
    in_ch.torque_z <= tz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // An item counts as outstanding from the moment it is queued for sending.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (typed_notes.size() != 0 || attitude_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input aqp_pkg::cfg_reg_t idx, input logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      aqp_pkg::CFG_INERTIA_X: inertia_q16[0] = value;
      aqp_pkg::CFG_INERTIA_Y: inertia_q16[1] = value;
      aqp_pkg::CFG_INERTIA_Z: inertia_q16[2] = value;
      aqp_pkg::CFG_TIME_STEP: step_q24 = value[27:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] pick_torque();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      2: return $signed($urandom_range(0, 32'h0000_0400)) - 32'sh0000_0200;
      default: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
    endcase
  endfunction

  initial begin
    logic [31:0] setting [SettingCount][4];
    int          sent;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = aqp_pkg::CFG_INERTIA_X;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.torque_x = '0;
    in_ch.torque_y = '0;
    in_ch.torque_z = '0;
    fail_count     = 0;
    torques_taken  = 0;
    results_seen   = 0;
    idle_cycles    = 0;
    send_idle_pct  = 9;
    recv_idle_pct  = 57;
    inertia_q16    = '{aqp_pkg::InertiaReset, aqp_pkg::InertiaReset, aqp_pkg::InertiaReset};
    step_q24       = aqp_pkg::TimeStepReset;
    body_rate      = '{0, 0, 0};
    attitude_q30   = '{aqp_pkg::OneQ30, 0, 0, 0};

    // Extremes first, including a zero inertia and a zero step; the rest random.
    setting[0] = '{32'd1, 32'd1, 32'd1, 32'd1};
    setting[1] = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h0fff_ffff};
    setting[2] = '{32'd0, 32'd65536, 32'hffff_ffff, 32'd0};
    setting[3] = '{32'd0, 32'd0, 32'd0, 32'd1677722};
    for (int k = 4; k < SettingCount; k++) begin
      for (int r = 0; r < 3; r++) setting[k][r] = $urandom_range(32'h0000_1000, 32'h0100_0000);
      setting[k][3] = $urandom_range(1, 32'h0200_0000);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_torque(directed_rows[i].tx, directed_rows[i].ty, directed_rows[i].tz,
                  directed_rows[i].typed, directed_rows[i].want);
    end

    sent = 0;
    for (int k = 0; k < SettingCount; k++) begin
      wait_drained();
      write_reg(aqp_pkg::CFG_INERTIA_X, setting[k][0]);
      write_reg(aqp_pkg::CFG_INERTIA_Y, setting[k][1]);
      write_reg(aqp_pkg::CFG_INERTIA_Z, setting[k][2]);
      write_reg(aqp_pkg::CFG_TIME_STEP, setting[k][3]);
      for (int n = 0; n < ItemsPerSetting; n++) begin
        if (sent < 183) begin
          send_idle_pct = 9;
          recv_idle_pct = 57;
        end else if (sent < 366) begin
          send_idle_pct = 57;
          recv_idle_pct = 9;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        send_torque(pick_torque(), pick_torque(), pick_torque(), 1'b0, '0);
        sent++;
        // Now and then the sender holds off until the block has emptied.
        if (n == ItemsPerSetting / 2) wait_drained();
      end
    end

    in_ch.valid <= 1'b0;
    while (typed_notes.size() != 0 || attitude_queue.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("Ran %0d torque transfers over %0d register settings; %0d results checked.",
             torques_taken, SettingCount + 1, results_seen);
    $display("Settings covered unit and maximum inertia, zero inertia, zero and maximum step.");
    if (fail_count == 0) begin
      $display("attitude_quaternion_propagator_tb OK");
    end else begin
      $display("attitude_quaternion_propagator_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/aqp_pkg.sv
rtl/core/aqp_if.sv
rtl/core/aqp_div.sv
rtl/core/aqp_sqrt.sv
rtl/core/aqp_dp.sv
rtl/core/aqp_ctrl.sv
rtl/core/attitude_quaternion_propagator.sv
test/attitude_quaternion_propagator_tb.sv
